[design/aurw_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_pkg: shared types and constants of the upsampling ring writer
// Ring geometry, rate limits, register map and the types passed between
// the register file, the frame front end, the queue and the writer.
// ---------------------------------------------------------------------------
package aurw_pkg;

	// ring geometry
	localparam int NUM_BUFFERS           = 4;
	localparam int SUBBUFFERS_PER_BUFFER = 4;
	localparam int SLOT_SAMPLES          = 1024;

	localparam int BUF_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int SUB_W = (SUBBUFFERS_PER_BUFFER > 1) ? $clog2(SUBBUFFERS_PER_BUFFER) : 1;
	localparam int OFF_W = (SLOT_SAMPLES > 1) ? $clog2(SLOT_SAMPLES) : 1;

	// rates
	localparam int OUT_RATE = 48000;
	localparam int MIN_RATE = 8000;
	localparam int PHASE_W  = 16;
	localparam int MAX_REPEAT = 6;
	localparam int CNT_W    = 3;

	// frame queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	// configuration port
	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_SOURCE_RATE  = 2'd0,
		REG_STEREO_MODE  = 2'd1,
		REG_WIDE_SAMPLES = 2'd2,
		REG_GAIN         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] source_rate;
		logic        stereo_mode;
		logic        wide_samples;
		logic [15:0] gain;
	} cfg_t;

	// one scaled frame and how many output beats it produces
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [CNT_W-1:0]   count;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage : aurw_pkg
`default_nettype wire

[design/audio_upsample_ring_writer_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// audio_upsample_ring_writer_unit: nearest-neighbor upsampler to 48 kHz
// Scales mono or stereo frames by a Q4.12 gain and repeats each frame
// into consecutive slots of a ring of sample buffers.
// ---------------------------------------------------------------------------
// Each accepted frame produces 0 to 6 output beats; a frame at source rate R
// yields about 48000/R beats (6 at 8 kHz, 1 at 48 kHz). The writer emits one
// beat per cycle while frames are queued and the sink is ready, from its single
// output register; a frame that yields no beat retires in the front end without
// a queue slot. The front end takes a new frame every cycle while the four-entry
// frame queue has room, so intake and output stall independently. A frame passes
// through the front-end stage register and the frame queue into the output
// register. Write configuration only while the block is idle.
// ---------------------------------------------------------------------------
module audio_upsample_ring_writer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [aurw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// frame input
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [15:0]          first_sample,
	input  wire logic signed [15:0]          second_sample,
	input  wire logic                        end_of_call,
	// ring write beats
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [15:0]               left_out,
	output logic signed [15:0]               right_out,
	output logic [1:0]                       buffer_index,
	output logic [1:0]                       subbuffer_index,
	output logic [9:0]                       slot_offset,
	output logic                             subbuffer_done,
	output logic                             buffer_ready,
	output logic                             last
);

	aurw_pkg::cfg_t         cfg;
	aurw_pkg::fifo_status_t q_status;
	aurw_pkg::frame_t       push_frame;
	aurw_pkg::frame_t       head;
	logic                   push;
	logic                   pop;

	// register accesses complete without wait states
	assign pready = 1'b1;

	aurw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// front end: widen, count repeats, scale, enqueue
	aurw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_sample  (first_sample),
		.second_sample (second_sample),
		.end_of_call   (end_of_call),
		.q_status      (q_status),
		.push          (push),
		.push_frame    (push_frame)
	);

	aurw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back end: repeat the head frame and walk the ring position
	aurw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_out        (left_out),
		.right_out       (right_out),
		.buffer_index    (buffer_index),
		.subbuffer_index (subbuffer_index),
		.slot_offset     (slot_offset),
		.subbuffer_done  (subbuffer_done),
		.buffer_ready    (buffer_ready),
		.last            (last)
	);

endmodule : audio_upsample_ring_writer_unit
`default_nettype wire

[design/aurw_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_regs: configuration register file
// APB-style write and read access to rate, channel mode, sample width
// and gain.
// ---------------------------------------------------------------------------
module aurw_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [aurw_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output aurw_pkg::cfg_t                   cfg
);

	aurw_pkg::cfg_t   cfg_q;
	aurw_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx   = aurw_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_rate  <= 16'(aurw_pkg::OUT_RATE);
			cfg_q.stereo_mode  <= 1'b0;
			cfg_q.wide_samples <= 1'b1;
			cfg_q.gain         <= 16'd4096;
		end else if (wr_en) begin
			unique case (idx)
				aurw_pkg::REG_SOURCE_RATE:  cfg_q.source_rate  <= pwdata[15:0];
				aurw_pkg::REG_STEREO_MODE:  cfg_q.stereo_mode  <= pwdata[0];
				aurw_pkg::REG_WIDE_SAMPLES: cfg_q.wide_samples <= pwdata[0];
				aurw_pkg::REG_GAIN:         cfg_q.gain         <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			aurw_pkg::REG_SOURCE_RATE:  prdata = {16'd0, cfg_q.source_rate};
			aurw_pkg::REG_STEREO_MODE:  prdata = {31'd0, cfg_q.stereo_mode};
			aurw_pkg::REG_WIDE_SAMPLES: prdata = {31'd0, cfg_q.wide_samples};
			aurw_pkg::REG_GAIN:         prdata = {16'd0, cfg_q.gain};
		endcase
	end

endmodule : aurw_regs
`default_nettype wire

[design/aurw_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_front: frame intake and classification
// Widens samples, steps the phase accumulator to find the repeat count,
// applies the gain and pushes the frame into the queue.
// ---------------------------------------------------------------------------
module aurw_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire aurw_pkg::cfg_t        cfg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [15:0]    first_sample,
	input  wire logic signed [15:0]    second_sample,
	input  wire logic                  end_of_call,
	input  wire aurw_pkg::fifo_status_t q_status,
	output logic                       push,
	output aurw_pkg::frame_t           push_frame
);

	localparam int SUM_W = 20;

	logic                            valid_s1;
	logic signed [15:0]              left_s1;
	logic signed [15:0]              right_s1;
	logic [aurw_pkg::CNT_W-1:0]      count_s1;
	logic [aurw_pkg::PHASE_W-1:0]    phase_q;

	logic                            accept;
	logic                            s1_done;
	logic [15:0]                     rate;
	logic [SUM_W-1:0]                sums [0:aurw_pkg::MAX_REPEAT];
	logic [aurw_pkg::CNT_W-1:0]      cnt_raw;
	logic [aurw_pkg::CNT_W-1:0]      cnt_fin;
	logic [aurw_pkg::PHASE_W-1:0]    phase_nxt;
	logic [aurw_pkg::PHASE_W-1:0]    phase_fin;
	logic signed [15:0]              first_w;
	logic signed [15:0]              second_w;

	function automatic logic signed [15:0] widen(input logic signed [15:0] raw,
		input logic wide);
		return wide ? raw : $signed({raw[7:0], 8'h00});
	endfunction

	// truncate toward zero, then saturate
	function automatic logic signed [15:0] scale_sample(input logic signed [15:0] s,
		input logic [15:0] g);
		logic signed [32:0] prod;
		logic signed [32:0] q;
		prod = s * $signed({1'b0, g});
		q = (prod + (prod[32] ? 33'sd4095 : 33'sd0)) >>> 12;
		if (q > 33'sd32767)
			return 16'sh7FFF;
		else if (q < -33'sd32768)
			return 16'sh8000;
		else
			return q[15:0];
	endfunction

	// clamp the rate into the supported range
	always_comb begin
		if (cfg.source_rate < 16'(aurw_pkg::MIN_RATE))
			rate = 16'(aurw_pkg::MIN_RATE);
		else if (cfg.source_rate > 16'(aurw_pkg::OUT_RATE))
			rate = 16'(aurw_pkg::OUT_RATE);
		else
			rate = cfg.source_rate;
	end

	// candidate output instants, each independent of the others
	always_comb begin
		for (int k = 0; k <= aurw_pkg::MAX_REPEAT; k++) begin
			sums[k] = SUM_W'(phase_q) + SUM_W'(rate) * SUM_W'(k);
		end
		cnt_raw = aurw_pkg::CNT_W'(1);
		for (int k = 1; k < aurw_pkg::MAX_REPEAT; k++) begin
			if (sums[k] < SUM_W'(aurw_pkg::OUT_RATE))
				cnt_raw = cnt_raw + aurw_pkg::CNT_W'(1);
		end
		phase_nxt = aurw_pkg::PHASE_W'(sums[cnt_raw] - SUM_W'(aurw_pkg::OUT_RATE));
		cnt_fin   = cnt_raw;
		phase_fin = phase_nxt;
		if (end_of_call) begin
			if (phase_nxt != '0)
				cnt_fin = cnt_raw - aurw_pkg::CNT_W'(1);
			phase_fin = '0;
		end
	end

	assign first_w  = widen(first_sample, cfg.wide_samples);
	assign second_w = widen(second_sample, cfg.wide_samples);

	// a frame with no output retires without a queue slot
	assign push     = valid_s1 && (count_s1 != '0) && !q_status.full;
	assign s1_done  = valid_s1 && ((count_s1 == '0) || !q_status.full);
	assign in_ready = !valid_s1 || s1_done;
	assign accept   = in_valid && in_ready;

	assign push_frame.left  = scale_sample(left_s1, cfg.gain);
	assign push_frame.right = scale_sample(right_s1, cfg.gain);
	assign push_frame.count = count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			phase_q  <= phase_fin;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= cfg.stereo_mode ? second_w : first_w;
			right_s1 <= first_w;
			count_s1 <= cnt_fin;
		end
	end

endmodule : aurw_front
`default_nettype wire

[design/aurw_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_fifo: frame queue
// Short queue of scaled frames between the front end and the writer.
// ---------------------------------------------------------------------------
module aurw_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire aurw_pkg::frame_t       push_frame,
	input  wire logic                   pop,
	output aurw_pkg::frame_t            head,
	output aurw_pkg::fifo_status_t      status
);

	aurw_pkg::frame_t               mem_q [0:aurw_pkg::FIFO_DEPTH-1];
	logic [aurw_pkg::PTR_W-1:0]     wr_ptr_q;
	logic [aurw_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [aurw_pkg::PTR_W:0]       fill_q;

	assign status.full  = (fill_q == (aurw_pkg::PTR_W+1)'(aurw_pkg::FIFO_DEPTH));
	assign status.empty = (fill_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + aurw_pkg::PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + aurw_pkg::PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + (aurw_pkg::PTR_W+1)'(1);
			else if (pop && !push)
				fill_q <= fill_q - (aurw_pkg::PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_frame;
	end

endmodule : aurw_fifo
`default_nettype wire

[design/aurw_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_back: ring writer
// Repeats the head frame into output beats and tracks the ring position.
// ---------------------------------------------------------------------------
module aurw_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire aurw_pkg::frame_t      head,
	input  wire aurw_pkg::fifo_status_t q_status,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [15:0]         left_out,
	output logic signed [15:0]         right_out,
	output logic [1:0]                 buffer_index,
	output logic [1:0]                 subbuffer_index,
	output logic [9:0]                 slot_offset,
	output logic                       subbuffer_done,
	output logic                       buffer_ready,
	output logic                       last
);

	logic [aurw_pkg::CNT_W-1:0] rep_q;
	logic [aurw_pkg::BUF_W-1:0] buf_q;
	logic [aurw_pkg::SUB_W-1:0] sub_q;
	logic [aurw_pkg::OFF_W-1:0] off_q;
	logic                       out_valid_q;

	logic                       load;
	logic                       is_last;
	logic                       off_wrap;
	logic                       sub_wrap;

	assign load     = !q_status.empty && (!out_valid_q || out_ready);
	assign is_last  = (rep_q + aurw_pkg::CNT_W'(1)) == head.count;
	assign pop      = load && is_last;
	assign off_wrap = (off_q == aurw_pkg::OFF_W'(aurw_pkg::SLOT_SAMPLES - 1));
	assign sub_wrap = (sub_q == aurw_pkg::SUB_W'(aurw_pkg::SUBBUFFERS_PER_BUFFER - 1));
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rep_q       <= '0;
			buf_q       <= '0;
			sub_q       <= '0;
			off_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load) begin
				rep_q <= is_last ? '0 : rep_q + aurw_pkg::CNT_W'(1);
				// advance the write position, wrapping slot, sub-buffer, buffer
				if (off_wrap) begin
					off_q <= '0;
					if (sub_wrap) begin
						sub_q <= '0;
						if (buf_q == aurw_pkg::BUF_W'(aurw_pkg::NUM_BUFFERS - 1))
							buf_q <= '0;
						else
							buf_q <= buf_q + aurw_pkg::BUF_W'(1);
					end else begin
						sub_q <= sub_q + aurw_pkg::SUB_W'(1);
					end
				end else begin
					off_q <= off_q + aurw_pkg::OFF_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_out        <= head.left;
			right_out       <= head.right;
			buffer_index    <= 2'(buf_q);
			subbuffer_index <= 2'(sub_q);
			slot_offset     <= 10'(off_q);
			subbuffer_done  <= off_wrap;
			buffer_ready    <= off_wrap && sub_wrap;
			last            <= is_last;
		end
	end

endmodule : aurw_back
`default_nettype wire

[design/aurw_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aurw_checker: port-level checks of the ring writer
// Watches the output beats for position and flag consistency.
// ---------------------------------------------------------------------------
module aurw_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic signed [15:0]          left_out,
	input wire logic signed [15:0]          right_out,
	input wire logic [1:0]                  buffer_index,
	input wire logic [1:0]                  subbuffer_index,
	input wire logic [9:0]                  slot_offset,
	input wire logic                        subbuffer_done,
	input wire logic                        buffer_ready,
	input wire logic                        last
);

	// hold a stalled beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(buffer_index) && $stable(subbuffer_index)
			&& $stable(slot_offset) && $stable(last))
		else $error("stalled output beat changed");

	// a sub-buffer closes only on its final slot
	a_sub_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && subbuffer_done |->
			slot_offset == 10'(aurw_pkg::SLOT_SAMPLES - 1))
		else $error("sub-buffer done away from its final slot");

	// a buffer closes only with its final sub-buffer
	a_buf_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && buffer_ready |-> subbuffer_done
			&& subbuffer_index == 2'(aurw_pkg::SUBBUFFERS_PER_BUFFER - 1))
		else $error("buffer ready without closing its final sub-buffer");

	// drop all beats during reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output beat during reset");

endmodule : aurw_checker

bind audio_upsample_ring_writer_unit aurw_checker u_checker (.*);
`default_nettype wire

[bench/audio_upsample_ring_writer_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_upsample_ring_writer_unit_tb: self-checking bench for the ring writer
// Sends frames over a valid/ready port with random gaps. Programs rate,
// channel mode, sample width and gain over APB between phases. Checks every
// ring write beat, field by field, against an in-bench model of the gain
// path, the repeat schedule and the ring position.
// ---------------------------------------------------------------------------
module audio_upsample_ring_writer_unit_tb;

	// Worst case is about 464 frames of up to 6 beats, each beat behind the longest
	// sink stall, plus sender gaps and the long hold-off. Allow far more.
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 12;     // covers the path from frame acceptance to output and frames with no beat
	localparam int HOLD_CYCLES  = 300;    // long sink hold-off that backs the frame queue up
	localparam int NUM_RANDOM   = 260;
	localparam int SWEEP_FRAMES = 180;    // 6 beats each at 8 kHz: closes a sub-buffer
	localparam int MAX_PRINTS   = 40;

	// one ring write beat as the block should present it
	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [1:0]         buf_idx;
		logic [1:0]         sub_idx;
		logic [9:0]         slot;
		logic               sub_done;
		logic               buf_done;
		logic               lst;
	} ring_beat_t;

	// directed frame with the configuration it needs; typed rows carry
	// left/right values that can be read straight off the spec
	typedef struct packed {
		logic [15:0] rate;
		logic        stereo;
		logic        wide;
		logic [15:0] gain;
		logic [15:0] first;
		logic [15:0] second;
		logic        eoc;
		logic        typed;
		logic [15:0] want_l;
		logic [15:0] want_r;
	} dir_row_t;

	dir_row_t dir_rows [24] = '{
		// unity gain, 48 kHz, mono, 16-bit: one beat per frame
		'{16'd48000, 1'b0, 1'b1, 16'd4096, 16'h7fff, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h7fff},
		'{16'd48000, 1'b0, 1'b1, 16'd4096, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h8000, 16'h8000},
		'{16'd48000, 1'b0, 1'b1, 16'd4096, 16'h0000, 16'hffff, 1'b0, 1'b1, 16'h0000, 16'h0000},
		// largest gain: truncation toward zero and saturation both ways
		'{16'd48000, 1'b0, 1'b1, 16'd65535, 16'h0001, 16'h0000, 1'b0, 1'b1, 16'd15, 16'd15},
		'{16'd48000, 1'b0, 1'b1, 16'd65535, 16'hffff, 16'h0000, 1'b0, 1'b1, 16'hfff1, 16'hfff1},
		'{16'd48000, 1'b0, 1'b1, 16'd65535, 16'h7fff, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h7fff},
		'{16'd48000, 1'b0, 1'b1, 16'd65535, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h8000, 16'h8000},
		// zero gain mutes
		'{16'd48000, 1'b0, 1'b1, 16'd0, 16'h3039, 16'h1234, 1'b0, 1'b1, 16'h0000, 16'h0000},
		// 8-bit samples: low byte only, times 256
		'{16'd48000, 1'b0, 1'b0, 16'd4096, 16'h007f, 16'h0000, 1'b0, 1'b1, 16'h7f00, 16'h7f00},
		'{16'd48000, 1'b0, 1'b0, 16'd4096, 16'hff80, 16'h0000, 1'b0, 1'b1, 16'h8000, 16'h8000},
		'{16'd48000, 1'b0, 1'b0, 16'd4096, 16'haa01, 16'h0000, 1'b0, 1'b1, 16'h0100, 16'h0100},
		// stereo swaps the channels
		'{16'd48000, 1'b1, 1'b1, 16'd4096, 16'h0064, 16'hff38, 1'b0, 1'b1, 16'hff38, 16'h0064},
		'{16'd48000, 1'b1, 1'b0, 16'd4096, 16'h5501, 16'h00ff, 1'b0, 1'b1, 16'hff00, 16'h0100},
		// 8 kHz: six repeats, and an end of call that lands on an exact phase
		'{16'd8000, 1'b0, 1'b1, 16'd4096, 16'h0005, 16'h0000, 1'b0, 1'b1, 16'h0005, 16'h0005},
		'{16'd8000, 1'b0, 1'b1, 16'd4096, 16'h0007, 16'h0000, 1'b1, 1'b1, 16'h0007, 16'h0007},
		// 44.1 kHz: end of call drops the tail, the second frame yields nothing
		'{16'd44100, 1'b0, 1'b1, 16'd4096, 16'h0009, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{16'd44100, 1'b0, 1'b1, 16'd4096, 16'h000b, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{16'd44100, 1'b0, 1'b1, 16'd4096, 16'h000d, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000},
		// out-of-range rates clamp to 8000 and 48000; then 11.025 kHz stereo 8-bit at half gain, and a 48 kHz end of call
		'{16'd0, 1'b0, 1'b1, 16'd4096, 16'h0015, 16'h0000, 1'b0, 1'b1, 16'h0015, 16'h0015},
		'{16'd65535, 1'b0, 1'b1, 16'd4096, 16'h0016, 16'h0000, 1'b0, 1'b1, 16'h0016, 16'h0016},
		'{16'd7999, 1'b0, 1'b1, 16'd4096, 16'h1234, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{16'd11025, 1'b1, 1'b0, 16'd2048, 16'h80c3, 16'h3c7f, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{16'd11025, 1'b1, 1'b0, 16'd2048, 16'h7f01, 16'hc380, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{16'd48000, 1'b0, 1'b1, 16'd4096, 16'hc001, 16'h4002, 1'b1, 1'b1, 16'hc001, 16'hc001}
	};

	// block ports; reset is driven low in the first time step
	logic                          clk;
	logic                          arst_n;
	logic                          psel          = 1'b0;
	logic                          penable       = 1'b0;
	logic                          pwrite        = 1'b0;
	logic [aurw_pkg::ADDR_W-1:0]   paddr         = '0;
	logic [31:0]                   pwdata        = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid      = 1'b0;
	logic                          in_ready;
	logic signed [15:0]            first_sample  = '0;
	logic signed [15:0]            second_sample = '0;
	logic                          end_of_call   = 1'b0;
	logic                          out_valid;
	logic                          out_ready     = 1'b0;
	logic signed [15:0]            left_out;
	logic signed [15:0]            right_out;
	logic [1:0]                    buffer_index;
	logic [1:0]                    subbuffer_index;
	logic [9:0]                    slot_offset;
	logic                          subbuffer_done;
	logic                          buffer_ready;
	logic                          last;

	// register shadow, as the block holds it after reset
	logic [15:0] rate_reg   = 16'd48000;
	logic        stereo_reg = 1'b0;
	logic        wide_reg   = 1'b1;
	logic [15:0] gain_reg   = 16'd4096;

	// model state: phase to the next output instant and next ring position
	int phase_pos = 0;
	int wr_buf    = 0;
	int wr_sub    = 0;
	int wr_slot   = 0;

	ring_beat_t pending_beats[$];

	int  error_count     = 0;
	int  beats_seen      = 0;
	int  frames_sent     = 0;
	int  silent_frames   = 0;
	int  cfg_writes      = 0;
	int  sub_closings    = 0;
	int  buf_closings    = 0;
	int  cycle_count     = 0;
	bit  sender_gaps_on  = 1'b1;
	bit  sink_gaps_on    = 1'b1;
	bit  drain_hold_req  = 1'b0;

	audio_upsample_ring_writer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_sample    (first_sample),
		.second_sample   (second_sample),
		.end_of_call     (end_of_call),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_out        (left_out),
		.right_out       (right_out),
		.buffer_index    (buffer_index),
		.subbuffer_index (subbuffer_index),
		.slot_offset     (slot_offset),
		.subbuffer_done  (subbuffer_done),
		.buffer_ready    (buffer_ready),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(string msg);
		if (error_count < MAX_PRINTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_error($sformatf("beat %0d %s: got %0d, want %0d", beats_seen, name, got, want));
	endtask

	// Widen, apply Q4.12 gain, truncate toward zero, saturate to 16 bits.
	function automatic logic [15:0] scale_sample(logic [15:0] raw);
		longint widened, prod, q;
		if (wide_reg)
			widened = longint'($signed(raw));
		else
			widened = longint'($signed(raw[7:0])) * 256;
		prod = widened * longint'(gain_reg);
		if (prod < 0)
			q = -((-prod) >>> 12);
		else
			q = prod >>> 12;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// Work out the beats one frame causes, queue them, advance phase and
	// ring position. Returns the number of beats.
	function automatic int schedule_ring_beats(logic [15:0] first, logic [15:0] second,
			logic eoc);
		int rate, pos, count, k;
		logic [15:0] lval, rval;
		ring_beat_t b;
		rate = rate_reg;
		if (rate < aurw_pkg::MIN_RATE)
			rate = aurw_pkg::MIN_RATE;
		if (rate > aurw_pkg::OUT_RATE)
			rate = aurw_pkg::OUT_RATE;
		if (stereo_reg) begin
			lval = scale_sample(second);
			rval = scale_sample(first);
		end else begin
			lval = scale_sample(first);
			rval = lval;
		end
		pos = phase_pos;
		count = 0;
		while (pos < aurw_pkg::OUT_RATE) begin
			count++;
			pos += rate;
		end
		pos -= aurw_pkg::OUT_RATE;
		// end of call: drop the beat that would overshoot, restart the phase
		if (eoc) begin
			if (pos != 0 && count > 0)
				count--;
			pos = 0;
		end
		phase_pos = pos;
		for (k = 0; k < count; k++) begin
			b.left     = lval;
			b.right    = rval;
			b.buf_idx  = wr_buf[1:0];
			b.sub_idx  = wr_sub[1:0];
			b.slot     = wr_slot[9:0];
			b.sub_done = 1'b0;
			b.buf_done = 1'b0;
			wr_slot++;
			if (wr_slot >= aurw_pkg::SLOT_SAMPLES) begin
				b.sub_done = 1'b1;
				wr_slot = 0;
				wr_sub++;
				if (wr_sub >= aurw_pkg::SUBBUFFERS_PER_BUFFER) begin
					b.buf_done = 1'b1;
					wr_sub = 0;
					wr_buf++;
					if (wr_buf >= aurw_pkg::NUM_BUFFERS)
						wr_buf = 0;
				end
			end
			b.lst = (k == count - 1);
			pending_beats.push_back(b);
		end
		return count;
	endfunction

	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return {8'($urandom_range(0, 255)), 8'h80};
			3: return {8'($urandom_range(0, 255)), 8'h7f};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Write one register (setup + access), then read it back.
	task automatic apb_write_reg(aurw_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] mask;
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= aurw_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the write at this edge; turn around into a read
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			aurw_pkg::REG_SOURCE_RATE: begin
				mask = 32'h0000_ffff;
				rate_reg = value[15:0];
			end
			aurw_pkg::REG_STEREO_MODE: begin
				mask = 32'h0000_0001;
				stereo_reg = value[0];
			end
			aurw_pkg::REG_WIDE_SAMPLES: begin
				mask = 32'h0000_0001;
				wide_reg = value[0];
			end
			default: begin
				mask = 32'h0000_ffff;
				gain_reg = value[15:0];
			end
		endcase
		if ((readback & mask) != (value & mask))
			report_error($sformatf("register %s reads %0d, wrote %0d", idx.name(),
				readback & mask, value & mask));
		cfg_writes++;
	endtask

	// Drop valid, wait for every expected beat, then let the block settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reprogram only what changes, and only once the block is idle.
	task automatic set_config(logic [15:0] rate, logic st, logic wd, logic [15:0] gn);
		if (rate != rate_reg || st != stereo_reg || wd != wide_reg || gn != gain_reg) begin
			wait_drained();
			if (rate != rate_reg)
				apb_write_reg(aurw_pkg::REG_SOURCE_RATE, 32'(rate));
			if (st != stereo_reg)
				apb_write_reg(aurw_pkg::REG_STEREO_MODE, 32'(st));
			if (wd != wide_reg)
				apb_write_reg(aurw_pkg::REG_WIDE_SAMPLES, 32'(wd));
			if (gn != gain_reg)
				apb_write_reg(aurw_pkg::REG_GAIN, 32'(gn));
		end
	endtask

	// Offer one frame and hold it until accepted. Valid stays high on return
	// so a back-to-back frame needs no second assignment in the same step.
	task automatic send_frame(logic [15:0] first, logic [15:0] second, logic eoc,
			logic typed, logic [15:0] want_l, logic [15:0] want_r);
		int n, i;
		ring_beat_t b;
		in_valid      <= 1'b1;
		first_sample  <= first;
		second_sample <= second;
		end_of_call   <= eoc;
		do
			@(posedge clk);
		while (!in_ready);
		n = schedule_ring_beats(first, second, eoc);
		if (n == 0)
			silent_frames++;
		// typed rows: compare against the hand-worked sample values
		if (typed) begin
			for (i = pending_beats.size() - n; i < pending_beats.size(); i++) begin
				b = pending_beats[i];
				b.left  = want_l;
				b.right = want_r;
				pending_beats[i] = b;
			end
		end
		frames_sent++;
	endtask

	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sink: random stalls, plus one long hold-off on request so the frame
	// queue fills and intake backs up.
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (drain_hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				drain_hold_req = 1'b0;
			end else begin
				stall = pick_gap(sink_gaps_on);
				out_ready <= (stall == 0);
				if (stall > 1)
					repeat (stall - 1) @(posedge clk);
			end
		end
	end

	// Beat checker: compare every accepted beat with the oldest expectation.
	always @(posedge clk) begin
		ring_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (subbuffer_done)
				sub_closings++;
			if (buffer_ready)
				buf_closings++;
			if (pending_beats.size() == 0) begin
				report_error($sformatf("beat %0d arrived with nothing expected", beats_seen));
			end else begin
				want = pending_beats.pop_front();
				check_field("left_out", left_out, want.left);
				check_field("right_out", right_out, want.right);
				check_field("buffer_index", buffer_index, want.buf_idx);
				check_field("subbuffer_index", subbuffer_index, want.sub_idx);
				check_field("slot_offset", slot_offset, want.slot);
				check_field("subbuffer_done", subbuffer_done, want.sub_done);
				check_field("buffer_ready", buffer_ready, want.buf_done);
				check_field("last", last, want.lst);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		dir_row_t   row;
		int         items, phase_end, call_len, k, burst_left;
		bit         noisy;
		logic       eoc;
		logic [15:0] rate, gn;

		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of samples and gain, both widths, both channel
		// modes, clamped rates, end-of-call drop and a frame with no beat.
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			set_config(row.rate, row.stereo, row.wide, row.gain);
			send_frame(row.first, row.second, row.eoc, row.typed, row.want_l, row.want_r);
			idle_gap(pick_gap(1'b1));
		end

		// Random: phases of fixed configuration, each a run of write calls
		// that close with end of call; some calls are broken up as noise.
		items = 0;
		burst_left = 0;
		while (items < NUM_RANDOM) begin
			case ($urandom_range(0, 11))
				0: rate = 16'd8000;
				1: rate = 16'd48000;
				2: rate = 16'd44100;
				3: rate = 16'd22050;
				4: rate = 16'd11025;
				5: rate = 16'd16000;
				6: rate = 16'd32000;
				7: rate = 16'd24000;
				8: rate = 16'd0;
				9: rate = 16'd65535;
				10: rate = 16'($urandom_range(8000, 48000));
				default: rate = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 7))
				0, 1, 2: gn = 16'd4096;
				3: gn = 16'd0;
				4: gn = 16'd65535;
				5: gn = 16'($urandom_range(0, 65535));
				default: gn = 16'($urandom_range(2048, 8192));
			endcase
			set_config(rate, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gn);
			sender_gaps_on = ($urandom_range(0, 3) != 0);
			sink_gaps_on   = ($urandom_range(0, 3) != 0);
			phase_end = items + $urandom_range(20, 60);
			while (items < phase_end && items < NUM_RANDOM) begin
				call_len = $urandom_range(1, 12);
				noisy = ($urandom_range(0, 4) == 0);
				for (k = 0; k < call_len && items < phase_end && items < NUM_RANDOM; k++) begin
					eoc = noisy ? 1'($urandom_range(0, 1)) : (k == call_len - 1);
					send_frame(pick_sample(), pick_sample(), eoc, 1'b0, 16'h0, 16'h0);
					items++;
					// hold the sink off and keep offering back to back
					if (items == 120) begin
						drain_hold_req = 1'b1;
						burst_left = 40;
					end
					// pause the sender until every beat is out
					if (items == 200)
						wait_drained();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						idle_gap(pick_gap(sender_gaps_on));
					end
				end
			end
		end

		// Ring sweep: 8 kHz back to back, enough beats to close at least
		// one sub-buffer.
		set_config(16'd8000, 1'($urandom_range(0, 1)), 1'b1, 16'd4096);
		sender_gaps_on = 1'b0;
		sink_gaps_on   = 1'b0;
		for (k = 0; k < SWEEP_FRAMES; k++)
			send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 15) == 0),
				1'b0, 16'h0, 16'h0);

		wait_drained();

		$display("Run covered %0d frames (%0d with no beat), %0d beats, %0d register writes",
			frames_sent, silent_frames, beats_seen, cfg_writes);
		$display("Ring closings seen: %0d sub-buffers, %0d buffers; %0d errors",
			sub_closings, buf_closings, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[audio_upsample_ring_writer_unit.f]
design/aurw_pkg.sv
design/aurw_regs.sv
design/aurw_front.sv
design/aurw_fifo.sv
design/aurw_back.sv
design/audio_upsample_ring_writer_unit.sv
design/aurw_checker.sv
bench/audio_upsample_ring_writer_unit_tb.sv
